### src/mlp_forward_sigmoid_4_4_1_assert.svh
// Assertion macros for the network RTL.
`ifndef MLP_FORWARD_SIGMOID_4_4_1_ASSERT_SVH
`define MLP_FORWARD_SIGMOID_4_4_1_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MLPFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MLPFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mlpfs_pkg.sv
// Constants, codes and arithmetic helpers of the 4-4-1 sigmoid network.
package mlpfs_pkg;

  localparam int INPUTS       = 4;
  localparam int HIDDEN_NODES = 4;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 64;
  localparam int LANE_W   = 16;
  localparam int ACT_W    = 16;

  localparam int HID_FRAC  = 24;
  localparam int OUT_FRAC  = 28;
  localparam int FRAC_DIFF = OUT_FRAC - HID_FRAC;

  // Hidden layer: 16x16 products, four of them plus bias.
  localparam int HPROD_W = 2 * SAMPLE_W;
  localparam int HZ_W    = HPROD_W + 2;
  // Output layer: unsigned activation times signed weight.
  localparam int OPROD_W = ACT_W + 1 + LANE_W;
  localparam int OZ_W    = OPROD_W + 2;
  // Magnitude fed to the sigmoid, in HID_FRAC units.
  localparam int MAG_W   = OZ_W;

  localparam logic signed [HZ_W-1:0] HID_BIAS = HZ_W'(64'd1 << HID_FRAC);
  localparam logic signed [OZ_W-1:0] OUT_BIAS = OZ_W'(64'd1 << OUT_FRAC);

  localparam logic [MAG_W-1:0] SIG_T_SAT  = MAG_W'(64'd5 << HID_FRAC);
  localparam logic [MAG_W-1:0] SIG_T_HIGH = MAG_W'(64'd19 << (HID_FRAC - 3));
  localparam logic [MAG_W-1:0] SIG_T_MID  = MAG_W'(64'd1 << HID_FRAC);

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT   = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ACT_W-1:0]           act_t;
  typedef logic [WORD_W-1:0]          word_t;

  // Signed weight k of a packed register word.
  function automatic logic signed [LANE_W-1:0] lane(word_t w, logic [1:0] k);
    return $signed(w[LANE_W*k +: LANE_W]);
  endfunction

  // PLAN sigmoid from sign and magnitude (HID_FRAC fraction bits), Q0.16 out.
  function automatic act_t plan_sigmoid(logic neg, logic [MAG_W-1:0] a);
    logic [ACT_W:0] p;
    logic [ACT_W:0] y;
    if (a >= SIG_T_SAT) begin
      p = 17'd65536;
    end else if (a >= SIG_T_HIGH) begin
      p = 17'(a >> (HID_FRAC - 11)) + 17'd55296;
    end else if (a >= SIG_T_MID) begin
      p = 17'(a >> (HID_FRAC - 13)) + 17'd40960;
    end else begin
      p = 17'(a >> (HID_FRAC - 14)) + 17'd32768;
    end
    y = neg ? (17'd65536 - p) : p;
    return (y > 17'd65535) ? 16'hFFFF : y[ACT_W-1:0];
  endfunction

endpackage

### src/mlpfs_sample_if.sv
// Sample channel: four signed Q4.12 inputs with valid/ready.
interface mlpfs_sample_if;
  import mlpfs_pkg::*;

  logic    valid;
  logic    ready;
  sample_t x_0;
  sample_t x_1;
  sample_t x_2;
  sample_t x_3;

  modport source (output valid, output x_0, output x_1, output x_2, output x_3,
                  input ready);
  modport sink   (input valid, input x_0, input x_1, input x_2, input x_3,
                  output ready);
endinterface

### src/mlpfs_result_if.sv
// Result channel: one Q0.16 prediction with valid/ready.
interface mlpfs_result_if;
  import mlpfs_pkg::*;

  logic valid;
  logic ready;
  act_t prediction;

  modport source (output valid, output prediction, input ready);
  modport sink   (input valid, input prediction, output ready);
endinterface

### src/mlpfs_cfg_if.sv
// Configuration write channel: register index and 64-bit data with valid/ready.
interface mlpfs_cfg_if;
  import mlpfs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/mlp_forward_sigmoid_4_4_1.sv
// Top level: pipelined forward pass of a 4-4-1 perceptron with PLAN sigmoid.
`include "mlp_forward_sigmoid_4_4_1_assert.svh"

// Each transaction on sample carries four signed Q4.12 values; the block
// answers each with exactly one Q0.16 prediction on result, in order. The
// datapath is an eight-stage pipeline (hidden multiply, hidden sum, hidden
// magnitude, hidden sigmoid, output multiply, output sum, output magnitude,
// output sigmoid), so a new sample is taken every cycle when nothing stalls,
// and its prediction is read from the last stage. Each stage carries its own
// valid bit and holds only while the stage ahead of it is full and blocked,
// so bubbles close up under back-pressure and a waiting result stops samples
// from entering only once all eight stages are full. The weights live in five
// 64-bit registers (hidden nodes 0..3, then the output node), four packed
// signed Q4.12 lanes each with lane 0 in the low bits; they reset to zero and
// are written through cfg, which is always ready. Writes to an index above
// the output register are dropped. Rewrite weights only while the pipeline is
// empty.
module mlp_forward_sigmoid_4_4_1 (
  input logic           clk,
  input logic           rst,
  mlpfs_sample_if.sink  sample,
  mlpfs_result_if.source result,
  mlpfs_cfg_if.sink     cfg
);
  import mlpfs_pkg::*;

  localparam int NSTAGE = 8;

  // Weight registers.
  word_t hw [4];
  word_t ow;

  // Per-stage valid bits and advance enables; adv[NSTAGE+1] is the sink.
  logic [NSTAGE:1]   v;
  logic [NSTAGE+1:1] adv;

  // Stage payloads.
  sample_t                   x4     [4];
  logic signed [HPROD_W-1:0] prod_h [HIDDEN_NODES][INPUTS];
  logic signed [HZ_W-1:0]    zh     [HIDDEN_NODES];
  logic signed [HZ_W-1:0]    zh_next[HIDDEN_NODES];
  logic [HZ_W-1:0]           magh   [HIDDEN_NODES];
  logic                      negh   [HIDDEN_NODES];
  act_t                      acth   [HIDDEN_NODES];
  logic signed [OPROD_W-1:0] prod_o [HIDDEN_NODES];
  logic signed [OZ_W-1:0]    zo;
  logic signed [OZ_W-1:0]    zo_next;
  logic [OZ_W-1:0]           mago;
  logic                      nego;
  act_t                      prediction;

  // Configuration: always ready, each write registered straight into its weight register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int h = 0; h < 4; h++) begin
        hw[h] <= '0;
      end
      ow <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HIDDEN_0: hw[0] <= cfg.data;
        REG_HIDDEN_1: hw[1] <= cfg.data;
        REG_HIDDEN_2: hw[2] <= cfg.data;
        REG_HIDDEN_3: hw[3] <= cfg.data;
        REG_OUTPUT:   ow    <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Back-pressure: a stage may load when it is empty or its content moves on.
  always_comb begin
    adv[NSTAGE+1] = result.ready;
    for (int s = NSTAGE; s >= 1; s--) begin
      adv[s] = !v[s] || adv[s+1];
    end
  end

  assign sample.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v[1] <= adv[1] ? sample.valid : v[1];
      for (int s = 2; s <= NSTAGE; s++) begin
        if (adv[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  assign x4[0] = sample.x_0;
  assign x4[1] = sample.x_1;
  assign x4[2] = sample.x_2;
  assign x4[3] = sample.x_3;

  // Stage 1: hidden-layer products.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int h = 0; h < HIDDEN_NODES; h++) begin
        for (int k = 0; k < INPUTS; k++) begin
          prod_h[h][k] <= HPROD_W'(x4[k] * lane(hw[h], 2'(k)));
        end
      end
    end
  end

  // Stage 2: hidden pre-activation, bias 1.0 in Q.24.
  always_comb begin
    for (int h = 0; h < HIDDEN_NODES; h++) begin
      zh_next[h] = HID_BIAS;
      for (int k = 0; k < INPUTS; k++) begin
        zh_next[h] = zh_next[h] + HZ_W'(prod_h[h][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      zh <= zh_next;
    end
  end

  // Stage 3: split into sign and magnitude.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int h = 0; h < HIDDEN_NODES; h++) begin
        negh[h] <= zh[h][HZ_W-1];
        magh[h] <= zh[h][HZ_W-1] ? HZ_W'(-zh[h]) : HZ_W'(zh[h]);
      end
    end
  end

  // Stage 4: hidden activations.
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int h = 0; h < HIDDEN_NODES; h++) begin
        acth[h] <= plan_sigmoid(negh[h], MAG_W'(magh[h]));
      end
    end
  end

  // Stage 5: output-layer products, activation taken as unsigned.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int h = 0; h < HIDDEN_NODES; h++) begin
        prod_o[h] <= OPROD_W'($signed({1'b0, acth[h]}) * lane(ow, 2'(h)));
      end
    end
  end

  // Stage 6: output pre-activation, bias 1.0 in Q.28.
  always_comb begin
    zo_next = OUT_BIAS;
    for (int h = 0; h < HIDDEN_NODES; h++) begin
      zo_next = zo_next + OZ_W'(prod_o[h]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      zo <= zo_next;
    end
  end

  // Stage 7: sign and magnitude of the output sum.
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      nego <= zo[OZ_W-1];
      mago <= zo[OZ_W-1] ? OZ_W'(-zo) : OZ_W'(zo);
    end
  end

  // Stage 8: output sigmoid. Thresholds are multiples of 16 in Q.28, so
  // dropping four fraction bits of the magnitude leaves every test exact.
  always_ff @(posedge clk) begin
    if (adv[8]) begin
      prediction <= plan_sigmoid(nego, MAG_W'(mago >> FRAC_DIFF));
    end
  end

  assign result.valid      = v[NSTAGE];
  assign result.prediction = prediction;

  `MLPFS_ASSERT_NEXT(a_sample_enters, sample.valid && sample.ready, v[1], "accepted sample did not enter stage 1")
  `MLPFS_ASSERT_NEXT(a_stage_keeps, v[4] && !adv[4], v[4], "stalled item dropped from stage 4")
  `MLPFS_ASSERT_NEXT(a_prod_holds, v[1] && !adv[1], $stable(prod_h[0][0]), "stage 1 payload changed while stalled")
  `MLPFS_ASSERT_NEXT(a_cfg_output, cfg.valid && cfg.ready && cfg.index == REG_OUTPUT, ow == $past(cfg.data), "output weight write lost")

endmodule
